// ----- rtl/core/ilbp_pkg.sv -----
// Package: shared types and constants of the item-location box parser.
package ilbp_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_ITEM_LIMIT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXTENT_LIMIT = 2'd1;

  localparam logic [15:0] ITEM_LIMIT_RST   = 16'd1024;
  localparam logic [15:0] EXTENT_LIMIT_RST = 16'd64;

  localparam logic [2:0] K_EXTENT    = 3'd0;
  localparam logic [2:0] K_NOEXT     = 3'd1;
  localparam logic [2:0] K_DONE      = 3'd2;
  localparam logic [2:0] K_TRUNC     = 3'd3;
  localparam logic [2:0] K_MALFORMED = 3'd4;

  typedef enum logic [12:0] {
    PH_VERSION = 13'h0001,
    PH_FLAGS   = 13'h0002,
    PH_SIZES0  = 13'h0004,
    PH_SIZES1  = 13'h0008,
    PH_ICOUNT  = 13'h0010,
    PH_ITEMID  = 13'h0020,
    PH_METHOD  = 13'h0040,
    PH_DREF    = 13'h0080,
    PH_BASE    = 13'h0100,
    PH_ECOUNT  = 13'h0200,
    PH_EINDEX  = 13'h0400,
    PH_EOFFSET = 13'h0800,
    PH_ELENGTH = 13'h1000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] item_id;
    logic [3:0]  construction;
    logic [15:0] data_ref;
    logic [63:0] item_base;
    logic [63:0] extent_offset;
    logic [63:0] extent_length;
    logic [15:0] extent_repeat;
    logic        last_of_run;
  } res_t;

endpackage

// ----- rtl/core/ilbp_in_if.sv -----
// Interface: byte channel into the parser.
interface ilbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/ilbp_out_if.sv -----
// Interface: record channel out of the parser.
interface ilbp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] item_id;
  logic [3:0]  construction;
  logic [15:0] data_ref;
  logic [63:0] item_base;
  logic [63:0] extent_offset;
  logic [63:0] extent_length;
  logic [15:0] extent_repeat;
  logic        last_of_run;

  modport source (output valid, output kind, output item_id, output construction,
                  output data_ref, output item_base, output extent_offset,
                  output extent_length, output extent_repeat, output last_of_run,
                  input ready);
  modport sink (input valid, input kind, input item_id, input construction,
                input data_ref, input item_base, input extent_offset,
                input extent_length, input extent_repeat, input last_of_run,
                output ready);
endinterface

// ----- rtl/core/item_location_box_parser.sv -----
// Top level: item-location box parser, byte stream in, location records out.
//
// Usage: the body of an item-location box enters on in_if one byte per beat,
// starting at the version byte, with last_byte set on the final byte. Each
// beat steps the parser state; a beat may cause zero, one or two records on
// out_if (extent record, item without extents, done, truncated, malformed),
// the last of them flagged by last_of_run. A record caused by a beat is
// offered on out_if in the cycle after that beat is accepted, behind any
// records still waiting in the queue. Throughput: one byte per cycle while
// in_if.ready is high. All field work for a beat is a single pass through
// the parser logic between the state registers; records go into a four-entry
// output queue, and in_if.ready is high while two entries are free.
// Stall: when the receiver holds out_if.ready low, records collect in the
// queue and input stops once more than two of them wait; nothing is lost.
// Reset: synchronous, active low; the parser waits for a version byte, the
// queue is empty, and the limits return to 1024 items and 64 extents.
// cfg_we writes item_limit (index 0) or extent_limit (index 1); other
// indexes are ignored. Writes belong to idle periods between boxes.
module item_location_box_parser
  import ilbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  ilbp_in_if.sink            in_if,
  ilbp_out_if.source         out_if,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  fbl;
    logic [63:0] acc;
    logic [7:0]  ver;
    logic [3:0]  ow;
    logic [3:0]  lw;
    logic [3:0]  bw;
    logic [3:0]  iw;
    logic [31:0] items_left;
    logic [15:0] ext_left;
    logic [31:0] cur_item;
    logic [3:0]  cur_meth;
    logic [15:0] cur_dref;
    logic [63:0] cur_base;
    logic [63:0] cur_eoff;
    logic        stopped;
  } pst_t;

  localparam pst_t PST_RST = '{phase: PH_VERSION, fbl: 4'd1, default: '0};

  pst_t        st_r, st_nxt;
  logic [15:0] item_limit_r, extent_limit_r;
  res_t        res [2];
  logic [1:0]  nres;

  res_t        q_r [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r;
  logic        in_acc, out_acc;

  function automatic logic has_method(pst_t s);
    return (s.ver == 8'd1) || (s.ver == 8'd2);
  endfunction

  function automatic logic [3:0] width_of(pst_t s, phase_t p);
    logic [3:0] w;
    unique case (p)
      PH_VERSION: w = 4'd1;
      PH_FLAGS:   w = 4'd3;
      PH_SIZES0:  w = 4'd1;
      PH_SIZES1:  w = 4'd1;
      PH_ICOUNT:  w = (s.ver < 8'd2) ? 4'd2 : 4'd4;
      PH_ITEMID:  w = (s.ver < 8'd2) ? 4'd2 : 4'd4;
      PH_METHOD:  w = 4'd2;
      PH_DREF:    w = 4'd2;
      PH_BASE:    w = s.bw;
      PH_ECOUNT:  w = 4'd2;
      PH_EINDEX:  w = has_method(s) ? s.iw : 4'd0;
      PH_EOFFSET: w = s.ow;
      PH_ELENGTH: w = s.lw;
      default:    w = 4'd1;
    endcase
    return w;
  endfunction

  function automatic pst_t enter_ph(pst_t s, phase_t p);
    pst_t t;
    t       = s;
    t.phase = p;
    t.fbl   = width_of(s, p);
    t.acc   = '0;
    return t;
  endfunction

  function automatic res_t mk_res(pst_t s, logic [2:0] k, logic [63:0] eo,
                                  logic [63:0] el, logic [15:0] rep);
    res_t r;
    r = '0;
    r.kind = k;
    if ((k == K_EXTENT) || (k == K_NOEXT)) begin
      r.item_id      = s.cur_item;
      r.construction = s.cur_meth;
      r.data_ref     = s.cur_dref;
      r.item_base    = s.cur_base;
    end
    r.extent_offset = eo;
    r.extent_length = el;
    r.extent_repeat = rep;
    return r;
  endfunction

  function automatic logic nib_ok(logic [3:0] v);
    return (v == 4'd0) || (v == 4'd4) || (v == 4'd8);
  endfunction

  assign in_if.ready = (cnt_r <= 3'd2);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_acc     = out_if.valid && out_if.ready;

  // Parser step: shift the byte in, then resolve completed and empty fields.
  always_comb begin
    pst_t       s;
    logic       emit_v;
    res_t       emit_r;
    logic       nxt_item;
    logic [15:0] cnt16;
    s        = st_r;
    res[0]   = '0;
    res[1]   = '0;
    nres     = 2'd0;
    emit_v   = 1'b0;
    emit_r   = '0;
    nxt_item = 1'b0;
    cnt16    = '0;
    if (in_acc) begin
      if (!s.stopped) begin
        s.acc = {s.acc[55:0], in_if.data_byte};
        if (s.fbl != 4'd0) begin
          s.fbl = s.fbl - 4'd1;
        end
        // At most four fields complete on one beat, empty ones included.
        for (int k = 0; k < 4; k++) begin
          emit_v   = 1'b0;
          nxt_item = 1'b0;
          if (!s.stopped && (s.fbl == 4'd0)) begin
            unique case (s.phase)
              PH_VERSION: begin
                s.ver = s.acc[7:0];
                s = enter_ph(s, PH_FLAGS);
              end
              PH_FLAGS:  s = enter_ph(s, PH_SIZES0);
              PH_SIZES0: begin
                s.ow = s.acc[7:4];
                s.lw = s.acc[3:0];
                s = enter_ph(s, PH_SIZES1);
              end
              PH_SIZES1: begin
                s.bw = s.acc[7:4];
                s.iw = s.acc[3:0];
                if (!nib_ok(s.ow) || !nib_ok(s.lw) || !nib_ok(s.bw) ||
                    !nib_ok(s.iw)) begin
                  emit_v = 1'b1;
                  emit_r = mk_res(s, K_MALFORMED, '0, '0, '0);
                  s.stopped = 1'b1;
                end else begin
                  s = enter_ph(s, PH_ICOUNT);
                end
              end
              PH_ICOUNT: begin
                if (s.acc[31:0] > {16'd0, item_limit_r}) begin
                  emit_v = 1'b1;
                  emit_r = mk_res(s, K_MALFORMED, '0, '0, '0);
                  s.stopped = 1'b1;
                end else begin
                  s.items_left = s.acc[31:0];
                  nxt_item = 1'b1;
                end
              end
              PH_ITEMID: begin
                s.cur_item = s.acc[31:0];
                s.cur_meth = '0;
                s.cur_dref = '0;
                s.cur_base = '0;
                s = enter_ph(s, has_method(s) ? PH_METHOD : PH_DREF);
              end
              PH_METHOD: begin
                s.cur_meth = s.acc[3:0];
                s = enter_ph(s, PH_DREF);
              end
              PH_DREF: begin
                s.cur_dref = s.acc[15:0];
                s = enter_ph(s, PH_BASE);
              end
              PH_BASE: begin
                s.cur_base = s.acc;
                s = enter_ph(s, PH_ECOUNT);
              end
              PH_ECOUNT: begin
                cnt16 = s.acc[15:0];
                if (cnt16 > extent_limit_r) begin
                  emit_v = 1'b1;
                  emit_r = mk_res(s, K_MALFORMED, '0, '0, '0);
                  s.stopped = 1'b1;
                end else if (cnt16 == 16'd0) begin
                  emit_v   = 1'b1;
                  emit_r   = mk_res(s, K_NOEXT, '0, '0, '0);
                  nxt_item = 1'b1;
                end else if ((s.ow == 4'd0) && (s.lw == 4'd0) &&
                             (width_of(s, PH_EINDEX) == 4'd0)) begin
                  // Zero-byte extent layout: one record for all extents.
                  emit_v   = 1'b1;
                  emit_r   = mk_res(s, K_EXTENT, '0, '0, cnt16);
                  nxt_item = 1'b1;
                end else begin
                  s.ext_left = cnt16 - 16'd1;
                  s.cur_eoff = '0;
                  s = enter_ph(s, PH_EINDEX);
                end
              end
              PH_EINDEX: s = enter_ph(s, PH_EOFFSET);
              PH_EOFFSET: begin
                s.cur_eoff = s.acc;
                s = enter_ph(s, PH_ELENGTH);
              end
              PH_ELENGTH: begin
                emit_v = 1'b1;
                emit_r = mk_res(s, K_EXTENT, s.cur_eoff, s.acc, 16'd1);
                if (s.ext_left != 16'd0) begin
                  s.ext_left = s.ext_left - 16'd1;
                  s.cur_eoff = '0;
                  s = enter_ph(s, PH_EINDEX);
                end else begin
                  nxt_item = 1'b1;
                end
              end
              default: begin
                emit_v = 1'b1;
                emit_r = mk_res(s, K_MALFORMED, '0, '0, '0);
                s.stopped = 1'b1;
              end
            endcase
            if (emit_v && (nres != 2'd2)) begin
              res[nres[0]] = emit_r;
              nres = nres + 2'd1;
            end
            // Move on to the next item, or close the box when none is left.
            if (nxt_item) begin
              if (s.items_left == 32'd0) begin
                if (nres != 2'd2) begin
                  res[nres[0]] = mk_res(s, K_DONE, '0, '0, '0);
                  nres = nres + 2'd1;
                end
                s.stopped = 1'b1;
              end else begin
                s.items_left = s.items_left - 32'd1;
                s = enter_ph(s, PH_ITEMID);
              end
            end
          end
        end
        // A box that ends before the parse is complete is truncated.
        if (in_if.last_byte && !s.stopped) begin
          if (nres != 2'd2) begin
            res[nres[0]] = mk_res(s, K_TRUNC, '0, '0, '0);
            nres = nres + 2'd1;
          end
          s.stopped = 1'b1;
        end
      end
      if (in_if.last_byte) begin
        s = PST_RST;
      end
      if (nres == 2'd1) begin
        res[0].last_of_run = 1'b1;
      end else if (nres == 2'd2) begin
        res[1].last_of_run = 1'b1;
      end
    end
    st_nxt = s;
  end

  // Parser state and limit registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= PST_RST;
      item_limit_r   <= ITEM_LIMIT_RST;
      extent_limit_r <= EXTENT_LIMIT_RST;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ITEM_LIMIT:   item_limit_r   <= cfg_wdata;
          CFG_EXTENT_LIMIT: extent_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Output queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + nres;
      rp_r  <= rp_r + {1'b0, out_acc};
      cnt_r <= cnt_r + {1'b0, nres} - {2'b0, out_acc};
    end
  end

  // Output queue storage.
  always_ff @(posedge clk) begin
    if (nres != 2'd0) begin
      q_r[wp_r] <= res[0];
    end
    if (nres == 2'd2) begin
      q_r[wp_r + 2'd1] <= res[1];
    end
  end

  assign out_if.valid         = (cnt_r != 3'd0);
  assign out_if.kind          = q_r[rp_r].kind;
  assign out_if.item_id       = q_r[rp_r].item_id;
  assign out_if.construction  = q_r[rp_r].construction;
  assign out_if.data_ref      = q_r[rp_r].data_ref;
  assign out_if.item_base     = q_r[rp_r].item_base;
  assign out_if.extent_offset = q_r[rp_r].extent_offset;
  assign out_if.extent_length = q_r[rp_r].extent_length;
  assign out_if.extent_repeat = q_r[rp_r].extent_repeat;
  assign out_if.last_of_run   = q_r[rp_r].last_of_run;

endmodule
